[src/lires_pkg.sv]
// ---------------------------------------------------------------------------
// lires_pkg: shared types and constants of the linear interpolation resampler
// Item layouts, configuration register indexes and output format codes.
// ---------------------------------------------------------------------------
package lires_pkg;

  typedef struct packed {
    logic [15:0] left_sample;
    logic [15:0] right_sample;
    logic        last_frame;
  } in_item_t;

  typedef struct packed {
    logic [15:0] out_left;
    logic [15:0] out_right;
    logic        last_output;
  } out_item_t;

  typedef struct packed {
    logic [19:0] phase_step;
    logic [15:0] start_phase;
    logic [23:0] main_outputs;
    logic [5:0]  tail_outputs;
    logic        stereo_mode;
    logic        wide_input;
    logic        signed_input;
    logic [1:0]  out_format;
  } cfg_t;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;

  localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_START_PHASE  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MAIN_OUTPUTS = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_TAIL_OUTPUTS = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_STEREO_MODE  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_WIDE_INPUT   = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_SIGNED_INPUT = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_OUT_FORMAT   = 3'd7;

  localparam logic [1:0] FMT_S8  = 2'd0;
  localparam logic [1:0] FMT_U8  = 2'd1;
  localparam logic [1:0] FMT_S16 = 2'd2;

  localparam logic [19:0] MIN_STEP   = 20'd2048;
  localparam logic [16:0] FRAC_ONE   = 17'h10000;
  localparam logic [5:0]  MAX_TAIL   = 6'd32;

endpackage

[src/lires_front.sv]
// ---------------------------------------------------------------------------
// lires_front: input queue of the resampler
// Accepts source frames and holds them until the sequencer takes them.
// ---------------------------------------------------------------------------
module lires_front import lires_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  output logic     q_valid,
  input  logic     q_ready,
  output in_item_t q_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  in_item_t         slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign in_ready = (count != FULL_CNT);
  assign q_valid  = (count != '0);
  assign q_item   = slots[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[src/lires_lerp.sv]
// ---------------------------------------------------------------------------
// lires_lerp: one channel of the interpolation datapath
// Conditions two raw samples, blends them with one multiply and formats.
// ---------------------------------------------------------------------------
module lires_lerp import lires_pkg::*; (
  input  logic [15:0] a_raw,
  input  logic [15:0] b_raw,
  input  logic [16:0] frac,
  input  logic        wide_input,
  input  logic        signed_input,
  input  logic [1:0]  out_format,
  output logic [15:0] result
);

  logic [15:0]        a_u;
  logic [15:0]        b_u;
  logic signed [16:0] diff;
  logic signed [34:0] prod;
  logic signed [34:0] acc;
  logic [31:0]        acc_lo;

  always_comb begin
    a_u = wide_input ? a_raw : {8'h00, a_raw[7:0]};
    b_u = wide_input ? b_raw : {8'h00, b_raw[7:0]};
    if (signed_input) begin
      if (wide_input) begin
        a_u[15] = ~a_u[15];
        b_u[15] = ~b_u[15];
      end else begin
        a_u[7] = ~a_u[7];
        b_u[7] = ~b_u[7];
      end
    end
  end

  // a*(1-f) + b*f is rewritten as a*2^16 + (b-a)*f, one multiplier.
  assign diff   = $signed({1'b0, b_u}) - $signed({1'b0, a_u});
  assign prod   = 35'(diff * $signed({1'b0, frac}));
  assign acc    = $signed({3'b000, a_u, 16'h0000}) + prod;
  assign acc_lo = acc[31:0];

  always_comb begin
    if (wide_input) begin
      result = acc_lo[31:16] - 16'h8000;
    end else begin
      case (out_format)
        FMT_S8:  result = {8'h00, acc_lo[23:16] - 8'h80};
        FMT_U8:  result = {8'h00, acc_lo[23:16]};
        default: result = acc_lo[23:8] - 16'h8000;
      endcase
    end
  end

endmodule

[src/lires_back.sv]
// ---------------------------------------------------------------------------
// lires_back: stream sequencer and output pipeline of the resampler
// Walks the phase over each frame pair, emits the tail, and formats results.
// ---------------------------------------------------------------------------
module lires_back import lires_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      q_valid,
  output logic      q_ready,
  input  in_item_t  q_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MAIN = 2'd1;
  localparam logic [1:0] S_TAIL = 2'd2;

  logic [1:0]  state;
  logic [15:0] prev_left;
  logic [15:0] prev_right;
  logic        have_prev;
  logic [15:0] phase_frac;
  logic [4:0]  frames_to_skip;
  logic [23:0] outputs_done;
  logic [4:0]  tail_left;
  in_item_t    cur;

  // Issue stage registers.
  logic        s1_valid;
  logic [15:0] s1_al;
  logic [15:0] s1_ar;
  logic [15:0] s1_bl;
  logic [15:0] s1_br;
  logic [16:0] s1_frac;
  logic        s1_fin;

  logic        adv;
  logic        pop;
  logic        hold_ok;
  logic [19:0] step_eff;
  logic [20:0] sum;
  logic        carry;
  logic        more;
  logic        main_emit;
  logic        main_end;
  logic        tail_emit;
  logic        finish;
  in_item_t    fin_item;
  logic [4:0]  tail_init;
  logic [15:0] res_l;
  logic [15:0] res_r;

  assign adv       = !out_valid || out_ready;
  assign pop       = (state == S_IDLE) && q_valid;
  assign q_ready   = (state == S_IDLE);
  assign hold_ok   = have_prev && (frames_to_skip == '0);
  assign step_eff  = (cfg.phase_step < MIN_STEP) ? MIN_STEP : cfg.phase_step;
  assign sum       = {5'b00000, phase_frac} + {1'b0, step_eff};
  assign carry     = (sum[20:16] != '0);
  assign more      = (outputs_done < cfg.main_outputs);
  assign main_emit = (state == S_MAIN) && adv && more;
  assign main_end  = (state == S_MAIN) && adv && (!more || carry);
  assign tail_emit = (state == S_TAIL) && adv;
  assign finish    = (pop && !hold_ok) || main_end;
  assign fin_item  = (state == S_IDLE) ? q_item : cur;

  always_comb begin
    if (cfg.tail_outputs == '0) begin
      tail_init = '0;
    end else if (cfg.tail_outputs > MAX_TAIL) begin
      tail_init = 5'd31;
    end else begin
      tail_init = 5'(cfg.tail_outputs - 6'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      have_prev      <= 1'b0;
      prev_left      <= '0;
      prev_right     <= '0;
      phase_frac     <= '0;
      frames_to_skip <= '0;
      outputs_done   <= '0;
      tail_left      <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (pop) begin
            cur <= q_item;
            if (hold_ok) begin
              state <= S_MAIN;
            end else if (!have_prev) begin
              phase_frac     <= cfg.start_phase;
              frames_to_skip <= '0;
              outputs_done   <= '0;
            end else begin
              frames_to_skip <= frames_to_skip - 1'b1;
            end
          end
        end
        S_MAIN: begin
          if (main_emit) begin
            outputs_done <= outputs_done + 1'b1;
            phase_frac   <= sum[15:0];
            if (carry) begin
              frames_to_skip <= sum[20:16] - 1'b1;
            end
          end
        end
        S_TAIL: begin
          if (adv) begin
            if (tail_left == '0) begin
              state <= S_IDLE;
            end else begin
              tail_left <= tail_left - 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase

      // End of a frame: it becomes the previous frame, or opens the tail.
      if (finish) begin
        prev_left  <= fin_item.left_sample;
        prev_right <= fin_item.right_sample;
        if (fin_item.last_frame) begin
          state          <= S_TAIL;
          tail_left      <= tail_init;
          have_prev      <= 1'b0;
          outputs_done   <= '0;
          frames_to_skip <= '0;
          phase_frac     <= cfg.start_phase;
        end else begin
          state     <= S_IDLE;
          have_prev <= 1'b1;
        end
      end
    end
  end

  // Issue stage: operands for one output.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= main_emit || tail_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_al <= prev_left;
      s1_ar <= prev_right;
      if (state == S_TAIL) begin
        s1_bl   <= prev_left;
        s1_br   <= prev_right;
        s1_frac <= FRAC_ONE;
        s1_fin  <= (tail_left == '0);
      end else begin
        s1_bl   <= cur.left_sample;
        s1_br   <= cur.right_sample;
        s1_frac <= {1'b0, phase_frac};
        s1_fin  <= 1'b0;
      end
    end
  end

  lires_lerp u_lerp_left (
    .a_raw        (s1_al),
    .b_raw        (s1_bl),
    .frac         (s1_frac),
    .wide_input   (cfg.wide_input),
    .signed_input (cfg.signed_input),
    .out_format   (cfg.out_format),
    .result       (res_l)
  );

  lires_lerp u_lerp_right (
    .a_raw        (s1_ar),
    .b_raw        (s1_br),
    .frac         (s1_frac),
    .wide_input   (cfg.wide_input),
    .signed_input (cfg.signed_input),
    .out_format   (cfg.out_format),
    .result       (res_r)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item.out_left    <= res_l;
      out_item.out_right   <= cfg.stereo_mode ? res_r : 16'h0000;
      out_item.last_output <= s1_fin;
    end
  end

endmodule

[src/linear_interp_audio_resampler.sv]
// ---------------------------------------------------------------------------
// linear_interp_audio_resampler: linear interpolation sample rate converter
// Turns a stream of mono or stereo source frames into interpolated output
// samples at a rate set by a 4.16 phase step, followed by a tail of copies
// of the last frame.
// ---------------------------------------------------------------------------
// The first result of a frame goes from the sequencer through the issue
// stage registers and then the output register.
// Throughput: while the output is not stalled, the sequencer emits one
// interpolated output per cycle after taking a frame (at most 32 per frame,
// plus a step if the main count runs out), then one tail copy per cycle.
// Reset (synchronous, rst high) empties the queue and pipeline, clears the
// stream state and returns the configuration registers to their defaults.
module linear_interp_audio_resampler import lires_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_item_t               in_item,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_item_t              out_item,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // Configuration registers, writes always taken. Software must write them only
  // while the stream is idle, so the back end sees stable values; not checked.
  cfg_t cfg;

  // Queue between the front end and the sequencer.
  logic     q_valid;
  logic     q_ready;
  in_item_t q_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.phase_step   <= 20'h10000;
      cfg.start_phase  <= '0;
      cfg.main_outputs <= '0;
      cfg.tail_outputs <= 6'd1;
      cfg.stereo_mode  <= 1'b0;
      cfg.wide_input   <= 1'b0;
      cfg.signed_input <= 1'b0;
      cfg.out_format   <= FMT_S16;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PHASE_STEP:   cfg.phase_step   <= cfg_data[19:0];
        REG_START_PHASE:  cfg.start_phase  <= cfg_data[15:0];
        REG_MAIN_OUTPUTS: cfg.main_outputs <= cfg_data[23:0];
        REG_TAIL_OUTPUTS: cfg.tail_outputs <= cfg_data[5:0];
        REG_STEREO_MODE:  cfg.stereo_mode  <= cfg_data[0];
        REG_WIDE_INPUT:   cfg.wide_input   <= cfg_data[0];
        REG_SIGNED_INPUT: cfg.signed_input <= cfg_data[0];
        REG_OUT_FORMAT:   cfg.out_format   <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // The front end buffers incoming frames so that the source is not held
  // up while the sequencer is busy with the outputs of an earlier frame.
  lires_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  // The back end tracks the phase, skips source frames on large steps,
  // counts main outputs, repeats the last frame for the tail, and runs the
  // multiply and formatting pipeline into the output register.
  lires_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
